### rtl/core/ovl_pkg.sv
// ----------------------------------------------------------------------------
// ovl_pkg
// shared codes and types for the ordered value list store
// ----------------------------------------------------------------------------
package ovl_pkg;

    localparam logic [2:0] MODE_APPEND     = 3'd0;
    localparam logic [2:0] MODE_INSERT     = 3'd1;
    localparam logic [2:0] MODE_REMOVE_AT  = 3'd2;
    localparam logic [2:0] MODE_REMOVE_VAL = 3'd3;
    localparam logic [2:0] MODE_TRUNCATE   = 3'd4;
    localparam logic [2:0] MODE_CLEAR      = 3'd5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LOWER = 2'd2,
        CELL_FROM_UPPER = 2'd3
    } t_cell_cmd;

endpackage

### rtl/core/ovl_cell.sv
// ----------------------------------------------------------------------------
// ovl_cell
// one list entry: holds, loads, or takes its lower or upper neighbour, and
// registers whether it matches the search key
// ----------------------------------------------------------------------------
module ovl_cell #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  ovl_pkg::t_cell_cmd i_cmd,
    input  logic [WIDTH-1:0]   i_load,
    input  logic [WIDTH-1:0]   i_lower,
    input  logic [WIDTH-1:0]   i_upper,
    input  logic [WIDTH-1:0]   i_key,
    input  logic               i_live,
    output logic [WIDTH-1:0]   o_data,
    output logic               o_match
);
    import ovl_pkg::*;

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;
    logic             r_match;

    always_comb begin
        case (i_cmd)
            CELL_HOLD:       n_data = r_data;
            CELL_LOAD:       n_data = i_load;
            CELL_FROM_LOWER: n_data = i_lower;
            CELL_FROM_UPPER: n_data = i_upper;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= i_live && (r_data == i_key);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

### rtl/core/ovl_locate.sv
// ----------------------------------------------------------------------------
// ovl_locate
// first-match search over the cell match flags: prefix or, position of the
// first match, and the mask of cells that shift down on removal
// ----------------------------------------------------------------------------
module ovl_locate #(
    parameter  int N  = 64,
    localparam int IW = $clog2(N)
) (
    input  logic [N-1:0]  i_match,
    output logic          o_found,
    output logic [IW-1:0] o_pos,
    output logic [N-1:0]  o_shift
);
    localparam int L = $clog2(N);

    logic [N-1:0]  w_pre;
    logic [N-1:0]  w_nxt;
    logic [N-1:0]  w_first;
    logic [IW-1:0] w_pos;

    // log-depth parallel prefix or
    always_comb begin
        w_pre = i_match;
        w_nxt = i_match;
        for (int k = 0; k < L; k++) begin
            w_nxt = w_pre;
            for (int i = (1 << k); i < N; i++) begin
                w_nxt[i] = w_pre[i] | w_pre[i - (1 << k)];
            end
            w_pre = w_nxt;
        end
    end

    assign w_first = i_match & ~{w_pre[N-2:0], 1'b0};

    always_comb begin
        w_pos = '0;
        for (int b = 0; b < IW; b++) begin
            for (int i = 0; i < N; i++) begin
                if (((i >> b) & 1) != 0) begin
                    w_pos[b] = w_pos[b] | w_first[i];
                end
            end
        end
    end

    assign o_found = w_pre[N-1];
    assign o_pos   = w_pos;
    assign o_shift = w_pre;

endmodule

### rtl/core/ordered_value_list_store_unit.sv
// ----------------------------------------------------------------------------
// ordered_value_list_store_unit
// bounded ordered list of signed values held in a row of entry cells
// ----------------------------------------------------------------------------
// Usage:
//   An item (i_mode, i_value, i_index) is taken at a clock edge with start
//   high and busy low. Modes: append, insert at index, remove at index,
//   remove by value, truncate to index, clear.
//   Every item gives one result item (o_status, o_found, o_position,
//   o_new_length), shown for exactly one cycle with o_done high; the
//   receiver cannot hold it off.
//   Timing: in the accept cycle every cell compares its entry with the
//   value; in the next cycle (busy high) the first-match search runs and
//   every cell loads, holds or takes a neighbour's entry at once. The
//   result appears in the cycle after that. A new item is not taken while
//   busy; the registered compare stage sits in front of the search.
//   Reset (i_rst_n low, synchronous) empties the list and drops any
//   pending result; entry contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module ordered_value_list_store_unit #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic [6:0]         i_index,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [5:0]         o_position,
    output logic [6:0]         o_new_length
);
    import ovl_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = (LW > 7) ? LW : 7;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state                   r_state;
    logic [2:0]               r_mode;
    logic [ELEMENT_WIDTH-1:0] r_value;
    logic [6:0]               r_index;
    logic [LW-1:0]            r_len;
    logic                     r_done;
    logic [1:0]               r_status;
    logic                     r_found;
    logic [5:0]               r_pos;
    logic [6:0]               r_new_len;

    logic [1:0]               n_status;
    logic [LW-1:0]            n_len;

    logic                     w_accept;
    logic                     w_exec;
    logic [ELEMENT_WIDTH-1:0] w_key;
    logic [CW-1:0]            w_idx;
    logic [CW-1:0]            w_len;
    logic                     w_full;
    logic                     w_app_ok;
    logic                     w_ins_ok;
    logic                     w_rmi_ok;
    logic                     w_rmv_ok;
    logic [CAPACITY-1:0]      w_match;
    logic [CAPACITY-1:0]      w_shift;
    logic                     w_found;
    logic [IW-1:0]            w_pos;
    logic [ELEMENT_WIDTH-1:0] w_data [CAPACITY];

    assign w_accept = start && (r_state == ST_IDLE);
    assign w_exec   = (r_state == ST_EXEC);
    assign w_key    = ELEMENT_WIDTH'(i_value);
    assign w_idx    = CW'(r_index);
    assign w_len    = CW'(r_len);
    assign w_full   = (r_len == LW'(CAPACITY));

    always_comb begin
        n_status = STATUS_OK;
        n_len    = r_len;
        w_app_ok = 1'b0;
        w_ins_ok = 1'b0;
        w_rmi_ok = 1'b0;
        w_rmv_ok = 1'b0;
        case (r_mode)
            MODE_APPEND: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_len    = r_len + LW'(1);
                    w_app_ok = w_exec;
                end
            end
            MODE_INSERT: begin
                if (w_idx > w_len) begin
                    n_status = STATUS_MISS;
                end else if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_len    = r_len + LW'(1);
                    w_ins_ok = w_exec;
                end
            end
            MODE_REMOVE_AT: begin
                if (w_idx >= w_len) begin
                    n_status = STATUS_MISS;
                end else begin
                    n_len    = r_len - LW'(1);
                    w_rmi_ok = w_exec;
                end
            end
            MODE_REMOVE_VAL: begin
                if (w_found) begin
                    n_len    = r_len - LW'(1);
                    w_rmv_ok = w_exec;
                end else begin
                    n_status = STATUS_MISS;
                end
            end
            MODE_TRUNCATE: begin
                if (w_idx > w_len) begin
                    n_status = STATUS_MISS;
                end else begin
                    n_len = LW'(w_idx);
                end
            end
            MODE_CLEAR: begin
                n_len = '0;
            end
            default: begin
                n_status = STATUS_MISS;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CW-1:0] CI = CW'(g);

        t_cell_cmd              w_cmd;
        logic                   w_live;
        logic [ELEMENT_WIDTH-1:0] w_lower;
        logic [ELEMENT_WIDTH-1:0] w_upper;

        if (g == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lower
            assign w_lower = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = w_data[g];
        end else begin : g_mid_upper
            assign w_upper = w_data[g+1];
        end

        assign w_live = (CI < w_len);

        always_comb begin
            w_cmd = CELL_HOLD;
            if (w_app_ok && (CI == w_len)) begin
                w_cmd = CELL_LOAD;
            end else if (w_ins_ok && (CI > w_idx)) begin
                w_cmd = CELL_FROM_LOWER;
            end else if (w_ins_ok && (CI == w_idx)) begin
                w_cmd = CELL_LOAD;
            end else if (w_rmi_ok && (CI >= w_idx)) begin
                w_cmd = CELL_FROM_UPPER;
            end else if (w_rmv_ok && w_shift[g]) begin
                w_cmd = CELL_FROM_UPPER;
            end
        end

        ovl_cell #(
            .WIDTH (ELEMENT_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_load  (r_value),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .i_key   (w_key),
            .i_live  (w_live),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    ovl_locate #(
        .N (CAPACITY)
    ) u_locate (
        .i_match (w_match),
        .o_found (w_found),
        .o_pos   (w_pos),
        .o_shift (w_shift)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_exec;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                    r_len   <= n_len;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_mode;
            r_value <= w_key;
            r_index <= i_index;
        end
        if (w_exec) begin
            r_status  <= n_status;
            r_found   <= (r_mode == MODE_REMOVE_VAL) && w_found;
            r_pos     <= ((r_mode == MODE_REMOVE_VAL) && w_found) ? 6'(w_pos) : 6'd0;
            r_new_len <= 7'(n_len);
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_position   = r_pos;
    assign o_new_length = r_new_len;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start execution");

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> o_done)
        else $error("execution cycle gave no result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still executing");

    a_error_keeps_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STATUS_OK)) |-> $stable(r_len))
        else $error("failed operation changed the list length");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_status == STATUS_OK))
        else $error("match reported with error status");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |-> (r_len <= LW'(CAPACITY)))
        else $error("list length beyond capacity");

endmodule
